// ----- hw/rtl/ips_pkg.sv -----
package ips_pkg;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  localparam logic [1:0] CFG_START_STEP     = 2'd0;
  localparam logic [1:0] CFG_START_DIVIDER  = 2'd1;
  localparam logic [1:0] CFG_START_LENGTH   = 2'd2;
  localparam logic [1:0] CFG_START_POSITION = 2'd3;

  localparam logic [3:0]  STEP_IDLE  = 4'd0;
  localparam logic [3:0]  STEP_FINAL = 4'd9;
  localparam logic [15:0] RELOAD_DIV = 16'h0004;
  localparam logic [15:0] FINAL_DIV  = 16'h0032;
  localparam logic [2:0]  LAST_BIT   = 3'd7;

  typedef struct packed {
    logic [3:0]  start_step;
    logic [15:0] start_divider;
    logic [7:0]  start_length;
    logic [7:0]  start_position;
  } cfg_t;

  typedef struct packed {
    logic       pin_level;
    logic       pin_written;
    logic       ticking;
    logic       finished;
    logic [3:0] sequence_step;
    logic       bit_mode;
  } result_t;

  function automatic logic [7:0] grow_by(input logic [3:0] step);
    logic [7:0] g;
    case (step)
      4'd4:    g = 8'd6;
      4'd6:    g = 8'd4;
      4'd8:    g = 8'd7;
      default: g = 8'd0;
    endcase
    return g;
  endfunction

endpackage

// ----- hw/rtl/indicator_pattern_sequencer.sv -----
// Indicator pattern sequencer: each tick request drives an indicator pin from a
// ten-step sequencer and a byte-pattern store.
// Input channel in_valid/in_ready carries func (tick, pattern write, start),
// a store address and a pattern byte. Output channel out_valid/out_ready
// returns one result per request: pin level, pin-written flag, ticking,
// finished, current step and bit mode.
// cfg_we/cfg_index/cfg_data write the start registers, taken at start requests.
// The accepting edge reads the pattern byte from the synchronous store; the
// edge that fires the execute stage updates state, writes back and loads the
// output register. Throughput is one request per cycle while the receiver
// takes results, set by the single read-modify-write of the store per request.
// A stalled receiver holds the result in the output register; one more request
// waits in the execute stage, after which in_ready drops.
// Reset clears all sequencer state and the start registers to their defaults;
// the pattern store is not cleared and must be written before it is used.
module indicator_pattern_sequencer
  import ips_pkg::*;
#(
  parameter int PATTERN_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_pattern_address,
  input  logic [7:0]  in_pattern_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_pin_level,
  output logic        out_pin_written,
  output logic        out_ticking,
  output logic        out_finished,
  output logic [3:0]  out_sequence_step,
  output logic        out_bit_mode,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(PATTERN_DEPTH);

  cfg_t          cfg_r;
  logic          e_valid_r;
  logic          out_valid_r;
  logic [1:0]    e_func_r;
  logic [7:0]    e_addr_r;
  logic [7:0]    e_byte_r;
  result_t       out_r;
  result_t       result;
  logic          e_fire;
  logic          in_acc;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [7:0]    rdata;

  assign e_fire   = e_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !e_valid_r || e_fire;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_step     <= 4'd0;
      cfg_r.start_divider  <= RELOAD_DIV;
      cfg_r.start_length   <= 8'd0;
      cfg_r.start_position <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_STEP:     cfg_r.start_step     <= cfg_data[3:0];
        CFG_START_DIVIDER:  cfg_r.start_divider  <= cfg_data;
        CFG_START_LENGTH:   cfg_r.start_length   <= cfg_data[7:0];
        CFG_START_POSITION: cfg_r.start_position <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      e_valid_r   <= in_acc || (e_valid_r && !e_fire);
      out_valid_r <= e_fire || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      e_func_r <= in_func;
      e_addr_r <= in_pattern_address;
      e_byte_r <= in_pattern_byte;
    end
    if (e_fire) begin
      out_r <= result;
    end
  end

  ips_store #(.PATTERN_DEPTH(PATTERN_DEPTH)) u_store (
    .clk   (clk),
    .re    (in_acc),
    .raddr (raddr),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .rdata (rdata)
  );

  ips_core #(.PATTERN_DEPTH(PATTERN_DEPTH)) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (e_fire),
    .func            (e_func_r),
    .pattern_address (e_addr_r),
    .pattern_byte    (e_byte_r),
    .rdata           (rdata),
    .cfg             (cfg_r),
    .raddr           (raddr),
    .we              (we),
    .waddr           (waddr),
    .wdata           (wdata),
    .result          (result)
  );

  assign out_valid         = out_valid_r;
  assign out_pin_level     = out_r.pin_level;
  assign out_pin_written   = out_r.pin_written;
  assign out_ticking       = out_r.ticking;
  assign out_finished      = out_r.finished;
  assign out_sequence_step = out_r.sequence_step;
  assign out_bit_mode      = out_r.bit_mode;

endmodule

// ----- hw/rtl/ips_store.sv -----
module ips_store
  import ips_pkg::*;
#(
  parameter int PATTERN_DEPTH = 32,
  localparam int AW = $clog2(PATTERN_DEPTH)
) (
  input  logic          clk,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [PATTERN_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // same-edge write wins over the old entry
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata_r <= wdata;
      end else begin
        rdata_r <= mem[raddr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/ips_core.sv -----
module ips_core
  import ips_pkg::*;
#(
  parameter int PATTERN_DEPTH = 32,
  localparam int AW = $clog2(PATTERN_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic [1:0]    func,
  input  logic [7:0]    pattern_address,
  input  logic [7:0]    pattern_byte,
  input  logic [7:0]    rdata,
  input  cfg_t          cfg,
  output logic [AW-1:0] raddr,
  output logic          we,
  output logic [AW-1:0] waddr,
  output logic [7:0]    wdata,
  output result_t       result
);

  logic [AW-1:0] idx_tbl [256];

  for (genvar g = 0; g < 256; g++) begin : g_idx
    assign idx_tbl[g] = AW'(g % PATTERN_DEPTH);
  end

  logic [3:0]  step_r, step_nxt;
  logic [15:0] div_r, div_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [2:0]  bitc_r, bitc_nxt;
  logic        half_r, half_nxt;
  logic        shift_r, shift_nxt;
  logic        tick_r, tick_nxt;
  logic        done_r, done_nxt;
  logic        pin_r, pin_nxt;
  logic        written;
  logic [15:0] div_dec;

  assign div_dec = div_r - 16'd1;

  always_comb begin
    step_nxt  = step_r;
    div_nxt   = div_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    bitc_nxt  = bitc_r;
    half_nxt  = half_r;
    shift_nxt = shift_r;
    tick_nxt  = tick_r;
    done_nxt  = done_r;
    pin_nxt   = pin_r;
    written   = 1'b0;
    we        = 1'b0;
    waddr     = idx_tbl[pos_r];
    wdata     = rdata >> 1;
    if (fire) begin
      case (func)
        FUNC_TICK: begin
          if (tick_r && shift_r) begin
            if (pos_r >= len_r) begin
              if (pos_r == len_r) begin
                shift_nxt = 1'b0;
                pin_nxt   = 1'b0;
                written   = 1'b1;
                div_nxt   = RELOAD_DIV;
                step_nxt  = step_r + 4'd1;
              end
            end else if (!half_r) begin
              pin_nxt  = rdata[0];
              written  = 1'b1;
              half_nxt = 1'b1;
            end else begin
              pin_nxt  = ~rdata[0];
              written  = 1'b1;
              half_nxt = 1'b0;
              if (bitc_r == LAST_BIT) begin
                bitc_nxt = 3'd0;
                pos_nxt  = pos_r + 8'd1;
              end else begin
                bitc_nxt = bitc_r + 3'd1;
                we       = 1'b1;
              end
            end
          end else if (tick_r && (step_r != STEP_IDLE) && (step_r <= STEP_FINAL)) begin
            div_nxt = div_dec;
            if (div_dec == 16'd0) begin
              if (step_r == STEP_FINAL) begin
                div_nxt  = FINAL_DIV;
                tick_nxt = 1'b0;
                done_nxt = 1'b1;
              end else if (step_r[0]) begin
                div_nxt  = RELOAD_DIV;
                step_nxt = step_r + 4'd1;
                pin_nxt  = 1'b1;
                written  = 1'b1;
              end else begin
                bitc_nxt  = 3'd0;
                len_nxt   = len_r + grow_by(step_r);
                pin_nxt   = rdata[0];
                written   = 1'b1;
                half_nxt  = 1'b1;
                shift_nxt = 1'b1;
              end
            end
          end
        end
        FUNC_WRITE: begin
          we    = 1'b1;
          waddr = idx_tbl[pattern_address];
          wdata = pattern_byte;
        end
        FUNC_START: begin
          step_nxt  = cfg.start_step;
          div_nxt   = cfg.start_divider;
          len_nxt   = cfg.start_length;
          pos_nxt   = cfg.start_position;
          bitc_nxt  = 3'd0;
          half_nxt  = 1'b0;
          shift_nxt = 1'b0;
          done_nxt  = 1'b0;
          tick_nxt  = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // next request reads the byte at the position this one leaves
  assign raddr = idx_tbl[pos_nxt];

  assign result.pin_level     = pin_nxt;
  assign result.pin_written   = written;
  assign result.ticking       = tick_nxt;
  assign result.finished      = done_nxt;
  assign result.sequence_step = step_nxt;
  assign result.bit_mode      = shift_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 4'd0;
      div_r   <= 16'd0;
      len_r   <= 8'd0;
      pos_r   <= 8'd0;
      bitc_r  <= 3'd0;
      half_r  <= 1'b0;
      shift_r <= 1'b0;
      tick_r  <= 1'b0;
      done_r  <= 1'b0;
      pin_r   <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      div_r   <= div_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      bitc_r  <= bitc_nxt;
      half_r  <= half_nxt;
      shift_r <= shift_nxt;
      tick_r  <= tick_nxt;
      done_r  <= done_nxt;
      pin_r   <= pin_nxt;
    end
  end

endmodule

// ----- verif/tb_indicator_pattern_sequencer.sv -----
`timescale 1ns / 100ps

module tb_indicator_pattern_sequencer;
  import ips_pkg::*;

  localparam int          STORE_DEPTH     = 32;
  localparam int          RANDOM_ITEMS    = 900;
  localparam int          MAX_GAP         = 12;
  localparam int          HOLD_OFF_CYCLES = 80;
  localparam int          DRAIN_SLACK     = 4;
  localparam int          END_SLACK       = 10;
  localparam int          WATCHDOG_LIMIT  = 1000;
  localparam logic [1:0]  FUNC_UNUSED     = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = FUNC_TICK;
  logic [7:0]  in_pattern_address = 8'h00;
  logic [7:0]  in_pattern_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_pin_level;
  logic        out_pin_written;
  logic        out_ticking;
  logic        out_finished;
  logic [3:0]  out_sequence_step;
  logic        out_bit_mode;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_START_STEP;
  logic [15:0] cfg_data = 16'h0000;

  // indicator state as predicted
  logic [7:0]  pat_mem [STORE_DEPTH];
  logic [3:0]  seq_step = 4'd0;
  logic [15:0] div_count = 16'd0;
  logic [7:0]  pat_len = 8'd0;
  logic [7:0]  pat_pos = 8'd0;
  logic [2:0]  bit_idx = 3'd0;
  logic        half_two = 1'b0;
  logic        in_bits = 1'b0;
  logic        run_en = 1'b0;
  logic        done_seen = 1'b0;
  logic        pin_q = 1'b0;

  // start registers as predicted
  logic [3:0]  cfg_step = 4'd0;
  logic [15:0] cfg_div = 16'd4;
  logic [7:0]  cfg_len = 8'd0;
  logic [7:0]  cfg_pos = 8'd0;

  result_t     expected_results [$];
  logic        sender_idle = 1'b0;
  logic        receiver_idle = 1'b0;
  logic        hold_off_req = 1'b0;
  int          requests_sent = 0;
  int          results_checked = 0;
  int          mismatch_count = 0;
  int          finals_reached = 0;
  int          settings_applied = 0;
  int          stalled_cycles = 0;

  indicator_pattern_sequencer u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_pattern_address (in_pattern_address),
    .in_pattern_byte    (in_pattern_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pin_level      (out_pin_level),
    .out_pin_written    (out_pin_written),
    .out_ticking        (out_ticking),
    .out_finished       (out_finished),
    .out_sequence_step  (out_sequence_step),
    .out_bit_mode       (out_bit_mode),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic predict_indicator(input logic [1:0] f, input logic [7:0] a,
                                   input logic [7:0] b, output result_t r);
    logic       wr;
    int         idx;
    logic [7:0] pat;
    wr = 1'b0;
    idx = pat_pos % STORE_DEPTH;
    pat = pat_mem[idx];
    case (f)
      FUNC_TICK: begin
        if (run_en && in_bits) begin
          if (pat_pos >= pat_len) begin
            if (pat_pos == pat_len) begin
              in_bits = 1'b0;
              pin_q = 1'b0;
              wr = 1'b1;
              div_count = RELOAD_DIV;
              seq_step = seq_step + 4'd1;
            end
          end else if (!half_two) begin
            pin_q = pat[0];
            wr = 1'b1;
            half_two = 1'b1;
          end else begin
            pin_q = ~pat[0];
            wr = 1'b1;
            half_two = 1'b0;
            if (bit_idx == LAST_BIT) begin
              bit_idx = 3'd0;
              pat_pos = pat_pos + 8'd1;
            end else begin
              bit_idx = bit_idx + 3'd1;
              pat_mem[idx] = pat >> 1;
            end
          end
        end else if (run_en && seq_step != STEP_IDLE && seq_step <= STEP_FINAL) begin
          div_count = div_count - 16'd1;
          if (div_count == 16'd0) begin
            if (seq_step == STEP_FINAL) begin
              div_count = FINAL_DIV;
              run_en = 1'b0;
              done_seen = 1'b1;
              finals_reached++;
            end else if (seq_step[0]) begin
              div_count = RELOAD_DIV;
              seq_step = seq_step + 4'd1;
              pin_q = 1'b1;
              wr = 1'b1;
            end else begin
              bit_idx = 3'd0;
              case (seq_step)
                4'd4:    pat_len = pat_len + 8'd6;
                4'd6:    pat_len = pat_len + 8'd4;
                4'd8:    pat_len = pat_len + 8'd7;
                default: pat_len = pat_len;
              endcase
              pin_q = pat[0];
              wr = 1'b1;
              half_two = 1'b1;
              in_bits = 1'b1;
            end
          end
        end
      end
      FUNC_WRITE: pat_mem[a % STORE_DEPTH] = b;
      FUNC_START: begin
        seq_step = cfg_step;
        div_count = cfg_div;
        pat_len = cfg_len;
        pat_pos = cfg_pos;
        bit_idx = 3'd0;
        half_two = 1'b0;
        in_bits = 1'b0;
        done_seen = 1'b0;
        run_en = 1'b1;
      end
      default: ;
    endcase
    r.pin_level = pin_q;
    r.pin_written = wr;
    r.ticking = run_en;
    r.finished = done_seen;
    r.sequence_step = seq_step;
    r.bit_mode = in_bits;
  endtask

  task automatic send_request(input logic [1:0] f, input logic [7:0] a, input logic [7:0] b);
    int      gap;
    result_t want;
    gap = sender_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_pattern_address <= a;
    in_pattern_byte <= b;
    do @(posedge clk); while (!in_ready);
    predict_indicator(f, a, b, want);
    expected_results.push_back(want);
    requests_sent++;
  endtask

  task automatic send_tick();
    send_request(FUNC_TICK, 8'($urandom), 8'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_start_regs(input logic [15:0] step_d, input logic [15:0] div_d,
                                  input logic [15:0] len_d, input logic [15:0] pos_d);
    logic [15:0] vals [4];
    logic [1:0]  regs [4];
    vals = '{step_d, div_d, len_d, pos_d};
    regs = '{CFG_START_STEP, CFG_START_DIVIDER, CFG_START_LENGTH, CFG_START_POSITION};
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_step = step_d[3:0];
    cfg_div = div_d;
    cfg_len = len_d[7:0];
    cfg_pos = pos_d[7:0];
    settings_applied++;
  endtask

  task automatic compare_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin : result_checker
    int      gap_left;
    int      hold_left;
    result_t want;
    gap_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("pin_level", 4'(want.pin_level), 4'(out_pin_level));
          compare_field("pin_written", 4'(want.pin_written), 4'(out_pin_written));
          compare_field("ticking", 4'(want.ticking), 4'(out_ticking));
          compare_field("finished", 4'(want.finished), 4'(out_finished));
          compare_field("sequence_step", want.sequence_step, out_sequence_step);
          compare_field("bit_mode", 4'(want.bit_mode), 4'(out_bit_mode));
          results_checked++;
        end
        gap_left = receiver_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
    end
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", stalled_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // every store entry gets written before anything can read it
  task automatic test_store_fill();
    logic [2:0] hi;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      hi = 3'($urandom);
      send_request(FUNC_WRITE, {hi, i[4:0]}, 8'($urandom));
    end
  endtask

  task automatic test_idle_items();
    send_tick();
    send_request(FUNC_UNUSED, 8'($urandom), 8'($urandom));
    send_request(FUNC_START, 8'h00, 8'h00);
    send_tick();
  endtask

  task automatic test_register_extremes();
    write_start_regs(16'd15, 16'd0, 16'd255, 16'd255);
    send_request(FUNC_START, 8'hff, 8'hff);
    send_tick();
    write_start_regs(16'd5, 16'd0, 16'd0, 16'd0);
    send_request(FUNC_START, 8'h00, 8'h00);
    send_tick();
    write_start_regs(16'd3, 16'hffff, 16'd0, 16'd0);
    send_request(FUNC_START, 8'h00, 8'h00);
    send_tick();
    write_start_regs(16'd9, 16'd1, 16'd0, 16'd0);
    send_request(FUNC_START, 8'h00, 8'h00);
    send_tick();
    send_tick();
    send_request(FUNC_START, 8'h00, 8'h00);
  endtask

  task automatic test_length_wrap_and_overrun();
    // length wraps to zero, so bit mode ends right after its first half-bit
    write_start_regs(16'd4, 16'd1, 16'd250, 16'd0);
    send_request(FUNC_START, 8'h00, 8'h00);
    repeat (2) send_tick();
    // position beyond length stalls bit mode for good
    write_start_regs(16'd2, 16'd2, 16'd3, 16'd200);
    send_request(FUNC_START, 8'h00, 8'h00);
    repeat (4) send_tick();
  endtask

  task automatic test_full_sequence();
    int guard;
    guard = 0;
    write_start_regs(16'd1, 16'd1, 16'd31, 16'd30);
    send_request(FUNC_START, 8'h00, 8'h00);
    while (run_en && guard < 2000) begin
      send_tick();
      guard++;
    end
    send_tick();
  endtask

  task automatic test_back_pressure();
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    write_start_regs(16'd1, 16'd2, 16'd2, 16'd0);
    send_request(FUNC_START, 8'h00, 8'h00);
    hold_off_req = 1'b1;
    repeat (40) send_tick();
    wait_drained();
    repeat (20) send_tick();
  endtask

  task automatic test_random_sequences();
    int          counted;
    int          cap;
    int          pick;
    logic        ignored;
    logic [1:0]  f;
    logic [3:0]  step;
    logic [15:0] div;
    logic [7:0]  len;
    logic [7:0]  pos;
    logic [15:0] noise;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      sender_idle = ($urandom_range(0, 2) != 0);
      receiver_idle = ($urandom_range(0, 2) != 0);
      noise = 16'($urandom);
      if ($urandom_range(0, 4) != 0) begin
        step = 4'($urandom_range(1, 9));
        div = 16'($urandom_range(1, 6));
        len = 8'($urandom_range(0, 6));
        pos = ($urandom_range(0, 5) != 0) ? 8'($urandom_range(0, len))
                                          : 8'($urandom_range(0, 255));
      end else begin
        step = 4'($urandom);
        div = 16'($urandom);
        len = 8'($urandom);
        pos = 8'($urandom);
      end
      write_start_regs({noise[15:4], step}, div, {noise[15:8], len}, {noise[7:0], pos});
      repeat ($urandom_range(0, 3)) begin
        send_request(FUNC_WRITE, 8'($urandom), 8'($urandom));
        counted++;
      end
      send_request(FUNC_START, 8'($urandom), 8'($urandom));
      counted++;
      cap = $urandom_range(20, 300);
      for (int i = 0; i < cap; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 88) f = FUNC_TICK;
        else if (pick < 95) f = FUNC_WRITE;
        else if (pick < 98) f = FUNC_UNUSED;
        else f = FUNC_START;
        ignored = (f == FUNC_UNUSED) || (f == FUNC_TICK && !run_en);
        send_request(f, 8'($urandom), 8'($urandom));
        if (!ignored) counted++;
        if (f == FUNC_TICK && ignored) break;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_store_fill();
    test_idle_items();
    test_register_extremes();
    test_length_wrap_and_overrun();
    test_full_sequence();
    test_back_pressure();
    test_random_sequences();
    wait_drained();
    repeat (END_SLACK) @(posedge clk);
    $display("run covered %0d requests and %0d checked results over %0d start settings,",
             requests_sent, results_checked, settings_applied);
    $display("with %0d sequences run through to the final step", finals_reached);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
